>>> src/rgb_lamp_chain_pulse_encoder_macros.svh
// Assertion macros for the RGB lamp chain pulse encoder.
// Included by the modules that carry concurrent assertions; depends on nothing.
`ifndef RGB_LAMP_CHAIN_PULSE_ENCODER_MACROS_SVH
`define RGB_LAMP_CHAIN_PULSE_ENCODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RLCPE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RLCPE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> src/rlcpe_pkg.sv
// Shared types, codes and the pulse expansion function of the lamp chain encoder.
// Depends on nothing; used by the interfaces, the cells, the output stage and the top.
package rlcpe_pkg;

   typedef enum logic [1:0] {
      CMD_SET     = 2'd0,
      CMD_CLEAR   = 2'd1,
      CMD_REFRESH = 2'd2
   } cmd_type;

   localparam int BYTE_W  = 8;
   localparam int LAMP_W  = 3 * BYTE_W;
   localparam int CODE_W  = 3 * BYTE_W;
   localparam int INDEX_W = 5;

   localparam logic [2:0] PULSE_ONE  = 3'b110;
   localparam logic [2:0] PULSE_ZERO = 3'b100;

   typedef logic [LAMP_W-1:0] lamp_type;
   typedef logic [CODE_W-1:0] code_type;

   // Per-cell control, driven by the top-level sequencer.
   typedef struct packed {
      logic clear;
      logic shift;
      logic load;
   } cell_ctrl_type;

   function automatic lamp_type pack_lamp(input logic [BYTE_W-1:0] green,
                                          input logic [BYTE_W-1:0] red,
                                          input logic [BYTE_W-1:0] blue);
      return {green, red, blue};
   endfunction

   // Bit 7 of the byte lands in code bits 23..21.
   function automatic code_type expand_byte(input logic [BYTE_W-1:0] value);
      code_type code;
      code = '0;
      for (int b = 0; b < BYTE_W; b++) begin
         code[3*b +: 3] = value[b] ? PULSE_ONE : PULSE_ZERO;
      end
      return code;
   endfunction

endpackage

>>> src/rlcpe_if.sv
// Valid/ready channel interfaces for requests and per-lamp results.
// Depends on rlcpe_pkg for field widths.
interface rlcpe_req_if
   import rlcpe_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [1:0]         command;
   logic [INDEX_W-1:0] lamp_index;
   logic [BYTE_W-1:0]  red;
   logic [BYTE_W-1:0]  green;
   logic [BYTE_W-1:0]  blue;

   modport source (output valid, command, lamp_index, red, green, blue, input ready);
   modport sink   (input valid, command, lamp_index, red, green, blue, output ready);
endinterface

interface rlcpe_rsp_if
   import rlcpe_pkg::*;
   ();
   logic               valid;
   logic               ready;
   code_type           green_code;
   code_type           red_code;
   code_type           blue_code;
   logic [INDEX_W-1:0] lamp_number;
   logic               last_lamp;

   modport source (output valid, green_code, red_code, blue_code, lamp_number, last_lamp,
                   input ready);
   modport sink   (input valid, green_code, red_code, blue_code, lamp_number, last_lamp,
                   output ready);
endinterface

>>> src/rlcpe_cell.sv
// One lamp cell of the chain: holds a lamp's green, red and blue bytes.
// Depends on rlcpe_pkg; loads a new value, clears, or takes its neighbor's value.
module rlcpe_cell
   import rlcpe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  lamp_type      load_value,
   input  lamp_type      neighbor_value,
   output lamp_type      value
);

   lamp_type value_ff;
   lamp_type value_in;

   always_comb begin
      value_in = value_ff;
      if (ctrl.clear) begin
         value_in = '0;
      end else if (ctrl.shift) begin
         value_in = neighbor_value;
      end else if (ctrl.load) begin
         value_in = load_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

>>> src/rlcpe_emit.sv
// Output stage: expands the lamp at the head of the chain into pulse codes and holds
// the result until it is taken. Depends on rlcpe_pkg and rlcpe_rsp_if.
module rlcpe_emit
   import rlcpe_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  lamp_type           lamp,
   input  logic [INDEX_W-1:0] number,
   input  logic               last,
   output logic               can_take,
   rlcpe_rsp_if.source        rsp_if
);

   logic               valid_ff;
   logic               valid_in;
   code_type           green_ff, red_ff, blue_ff;
   logic [INDEX_W-1:0] number_ff;
   logic               last_ff;

   assign can_take = !valid_ff || rsp_if.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         green_ff  <= expand_byte(lamp[2*BYTE_W +: BYTE_W]);
         red_ff    <= expand_byte(lamp[BYTE_W +: BYTE_W]);
         blue_ff   <= expand_byte(lamp[0 +: BYTE_W]);
         number_ff <= number;
         last_ff   <= last;
      end
   end

   assign rsp_if.valid       = valid_ff;
   assign rsp_if.green_code  = green_ff;
   assign rsp_if.red_code    = red_ff;
   assign rsp_if.blue_code   = blue_ff;
   assign rsp_if.lamp_number = number_ff;
   assign rsp_if.last_lamp   = last_ff;

endmodule

>>> src/rgb_lamp_chain_pulse_encoder.sv
// RGB lamp chain pulse encoder. Lamp values live in a ring of LAMPS cells, one per
// lamp. A set or clear request does not make the block busy, so the next request
// may follow it at once. A refresh request holds the request channel while the ring
// rotates once, handing lamp 0, 1, ... to the output stage one per cycle while the
// result channel is not stalled; after a full turn every lamp is back in its own
// cell. Results leave through one output register; an accepted refresh first sets
// the busy register, and the output register then takes the first result.
`include "rgb_lamp_chain_pulse_encoder_macros.svh"

module rgb_lamp_chain_pulse_encoder
   import rlcpe_pkg::*;
#(
   parameter int LAMPS = 24
) (
   input  logic        clock,
   input  logic        reset,
   rlcpe_req_if.sink   req_if,
   rlcpe_rsp_if.source rsp_if
);

   localparam int POS_W = (LAMPS > 1) ? $clog2(LAMPS) : 1;

   logic               busy_ff, busy_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [INDEX_W-1:0] num_ff, num_in;

   logic          accept;
   logic          can_take;
   logic          shift;
   logic          last;
   logic          do_set;
   logic          do_clear;
   logic          do_refresh;
   lamp_type      new_lamp;
   lamp_type      cell_value [LAMPS];
   cell_ctrl_type cell_ctrl  [LAMPS];

   assign req_if.ready = !busy_ff;
   assign accept       = req_if.valid && req_if.ready;
   assign new_lamp     = pack_lamp(req_if.green, req_if.red, req_if.blue);

   always_comb begin
      do_set     = 1'b0;
      do_clear   = 1'b0;
      do_refresh = 1'b0;
      case (cmd_type'(req_if.command))
         CMD_SET:     do_set     = accept;
         CMD_CLEAR:   do_clear   = accept;
         CMD_REFRESH: do_refresh = accept;
         default:     ;
      endcase
   end

   assign shift = busy_ff && can_take;
   assign last  = (pos_ff == POS_W'(LAMPS - 1));

   // The ring: cell i takes from cell i+1, and the last cell from cell 0.
   for (genvar i = 0; i < LAMPS; i++) begin : g_cell
      always_comb begin
         cell_ctrl[i].clear = do_clear;
         cell_ctrl[i].shift = shift;
         cell_ctrl[i].load  = do_set && ({27'd0, req_if.lamp_index} == 32'(i));
      end

      rlcpe_cell u_cell (
         .clock          (clock),
         .reset          (reset),
         .ctrl           (cell_ctrl[i]),
         .load_value     (new_lamp),
         .neighbor_value (cell_value[(i + 1) % LAMPS]),
         .value          (cell_value[i])
      );
   end

   always_comb begin
      busy_in = busy_ff;
      pos_in  = pos_ff;
      num_in  = num_ff;
      if (do_refresh) begin
         busy_in = 1'b1;
         pos_in  = '0;
         num_in  = '0;
      end else if (shift) begin
         pos_in = pos_ff + POS_W'(1);
         num_in = num_ff + INDEX_W'(1);
         if (last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= '0;
         num_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         pos_ff  <= pos_in;
         num_ff  <= num_in;
      end
   end

   rlcpe_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .take     (shift),
      .lamp     (cell_value[0]),
      .number   (num_ff),
      .last     (last),
      .can_take (can_take),
      .rsp_if   (rsp_if)
   );

   `RLCPE_ASSERT_NEXT(a_refresh_starts_run, clock, reset, do_refresh, busy_ff && pos_ff == '0)
   `RLCPE_ASSERT_NEXT(a_run_ends_on_last, clock, reset, shift && last, !busy_ff && rsp_if.valid && rsp_if.last_lamp)
   `RLCPE_ASSERT_SAME(a_last_number, clock, reset, shift && last, num_ff == INDEX_W'(LAMPS - 1))

endmodule

>>> bench/testbench.sv
// Self-checking bench for the RGB lamp chain pulse encoder: table-driven directed
// requests, then random ones, with a lamp store mirror predicting each refresh.
// Depends on rlcpe_pkg, the rlcpe_req_if/rlcpe_rsp_if interfaces and the encoder top.
`timescale 1ns / 100ps

module testbench;
   import rlcpe_pkg::*;

   localparam int         LAMPS         = 24;
   localparam int         RANDOM_ITEMS  = 300;
   localparam logic [1:0] CMD_UNUSED    = 2'd3;
   localparam code_type   ZERO_CODE     = 24'h924924;
   localparam code_type   ONE_CODE      = 24'hDB6DB6;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [INDEX_W-1:0] idx;
      logic [BYTE_W-1:0]  red;
      logic [BYTE_W-1:0]  green;
      logic [BYTE_W-1:0]  blue;
      logic               typed;
      code_type           green_code;
      code_type           red_code;
      code_type           blue_code;
   } stim_row_type;

   typedef struct {
      code_type           green_code;
      code_type           red_code;
      code_type           blue_code;
      logic [INDEX_W-1:0] lamp_number;
      logic               last_lamp;
   } lamp_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rlcpe_req_if req_bus ();
   rlcpe_rsp_if rsp_bus ();

   rgb_lamp_chain_pulse_encoder #(.LAMPS(LAMPS)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   always #5 clock = ~clock;

   lamp_type        lamp_mirror [LAMPS];
   lamp_result_type pending_lamps [$];
   stim_row_type    directed_rows [19];
   int              mismatches    = 0;
   int              lamps_checked = 0;
   int              requests_sent = 0;
   int              refreshes     = 0;
   int              send_burst    = 0;

   function automatic code_type pulse_code(input logic [BYTE_W-1:0] value);
      code_type code;
      code = '0;
      for (int i = BYTE_W - 1; i >= 0; i--) begin
         code = {code[CODE_W-4:0], value[i] ? PULSE_ONE : PULSE_ZERO};
      end
      return code;
   endfunction

   // Biased toward all-zero and all-one bytes, since those give the extreme codes.
   function automatic logic [BYTE_W-1:0] pick_byte();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 20) return 8'h00;
      if (sel < 30) return 8'hFF;
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   task automatic report_mismatch(input string what, input int lamp,
                                  input logic [31:0] got, input logic [31:0] want);
      $display("MISMATCH %s (lamp %0d): got %h, want %h", what, lamp, got, want);
      mismatches++;
   endtask

   // Mirrors the lamp store and queues the results a refresh is going to emit.
   task automatic apply_request(input stim_row_type row);
      lamp_result_type entry;
      lamp_type        value;
      case (row.cmd)
         CMD_SET: begin
            if (int'(row.idx) < LAMPS) lamp_mirror[row.idx] = {row.green, row.red, row.blue};
         end
         CMD_CLEAR: begin
            for (int i = 0; i < LAMPS; i++) lamp_mirror[i] = '0;
         end
         CMD_REFRESH: begin
            refreshes++;
            for (int i = 0; i < LAMPS; i++) begin
               value             = lamp_mirror[i];
               entry.green_code  = pulse_code(value[23:16]);
               entry.red_code    = pulse_code(value[15:8]);
               entry.blue_code   = pulse_code(value[7:0]);
               entry.lamp_number = INDEX_W'(i);
               entry.last_lamp   = (i == LAMPS - 1);
               if (row.typed && int'(row.idx) == i) begin
                  entry.green_code = row.green_code;
                  entry.red_code   = row.red_code;
                  entry.blue_code  = row.blue_code;
               end
               pending_lamps.push_back(entry);
            end
         end
         default: ;
      endcase
   endtask

   function automatic int pick_gap();
      int sel;
      if (send_burst > 0) begin
         send_burst--;
         return 0;
      end
      sel = $urandom_range(0, 99);
      if (sel < 5) send_burst = $urandom_range(10, 30);
      if (sel < 50) return 0;
      if (sel < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 24);
   endfunction

   // Called at a falling edge; returns at a falling edge after the request is taken.
   task automatic send_request(input stim_row_type row);
      int gap;
      req_bus.command    <= row.cmd;
      req_bus.lamp_index <= row.idx;
      req_bus.red        <= row.red;
      req_bus.green      <= row.green;
      req_bus.blue       <= row.blue;
      req_bus.valid      <= 1'b1;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      apply_request(row);
      requests_sent++;
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   initial begin
      req_bus.valid      = 1'b0;
      req_bus.command    = CMD_SET;
      req_bus.lamp_index = '0;
      req_bus.red        = '0;
      req_bus.green      = '0;
      req_bus.blue       = '0;
      rsp_bus.ready      = 1'b0;
      for (int i = 0; i < LAMPS; i++) lamp_mirror[i] = '0;
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // Result-side backpressure: runs of ready high or low, mostly short.
   initial begin : ready_gen
      int   run_left;
      int   sel;
      logic level;
      run_left = 0;
      level    = 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (run_left == 0) begin
            sel = $urandom_range(0, 99);
            if (sel < 8) begin
               level    = 1'b0;
               run_left = $urandom_range(10, 24);
            end else if (sel < 45) begin
               level    = 1'b0;
               run_left = $urandom_range(1, 3);
            end else if (sel < 55) begin
               level    = 1'b1;
               run_left = $urandom_range(30, 80);
            end else begin
               level    = 1'b1;
               run_left = $urandom_range(1, 6);
            end
         end
         rsp_bus.ready <= level;
         run_left--;
      end
   end

   always @(posedge clock) begin
      lamp_result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_lamps.size() == 0) begin
            report_mismatch("unexpected result", int'(rsp_bus.lamp_number),
                            32'(rsp_bus.green_code), 32'd0);
         end else begin
            want = pending_lamps.pop_front();
            lamps_checked++;
            if (rsp_bus.green_code !== want.green_code)
               report_mismatch("green_code", int'(want.lamp_number),
                               32'(rsp_bus.green_code), 32'(want.green_code));
            if (rsp_bus.red_code !== want.red_code)
               report_mismatch("red_code", int'(want.lamp_number),
                               32'(rsp_bus.red_code), 32'(want.red_code));
            if (rsp_bus.blue_code !== want.blue_code)
               report_mismatch("blue_code", int'(want.lamp_number),
                               32'(rsp_bus.blue_code), 32'(want.blue_code));
            if (rsp_bus.lamp_number !== want.lamp_number)
               report_mismatch("lamp_number", int'(want.lamp_number),
                               32'(rsp_bus.lamp_number), 32'(want.lamp_number));
            if (rsp_bus.last_lamp !== want.last_lamp)
               report_mismatch("last_lamp", int'(want.lamp_number),
                               32'(rsp_bus.last_lamp), 32'(want.last_lamp));
         end
      end
   end

   initial begin : stimulus
      stim_row_type row;
      int           useful;
      int           sel;
      logic         paused;

      // Rows with typed codes check the lamp named by idx; the rest rely on the mirror.
      directed_rows = '{
         '{CMD_REFRESH, 5'd0,  8'h00, 8'h00, 8'h00, 1'b1, ZERO_CODE, ZERO_CODE, ZERO_CODE},
         '{CMD_SET,     5'd0,  8'hFF, 8'hFF, 8'hFF, 1'b0, 24'h0, 24'h0, 24'h0},
         '{CMD_SET,     5'd23, 8'h00, 8'hFF, 8'h00, 1'b0, 24'h0, 24'h0, 24'h0},
         '{CMD_SET,     5'd5,  8'hAA, 8'h55, 8'h0F, 1'b0, 24'h0, 24'h0, 24'h0},
         '{CMD_SET,     5'd24, 8'h12, 8'h34, 8'h56, 1'b0, 24'h0, 24'h0, 24'h0},
         '{CMD_SET,     5'd31, 8'hFF, 8'hFF, 8'hFF, 1'b0, 24'h0, 24'h0, 24'h0},
         '{CMD_UNUSED,  5'd0,  8'h00, 8'h00, 8'h00, 1'b0, 24'h0, 24'h0, 24'h0},
         '{CMD_REFRESH, 5'd0,  8'h00, 8'h00, 8'h00, 1'b1, ONE_CODE, ONE_CODE, ONE_CODE},
         '{CMD_REFRESH, 5'd23, 8'h00, 8'h00, 8'h00, 1'b1, ONE_CODE, ZERO_CODE, ZERO_CODE},
         '{CMD_SET,     5'd1,  8'h80, 8'h01, 8'h7F, 1'b0, 24'h0, 24'h0, 24'h0},
         '{CMD_SET,     5'd2,  8'h01, 8'h80, 8'hFE, 1'b0, 24'h0, 24'h0, 24'h0},
         '{CMD_REFRESH, 5'd24, 8'h00, 8'h00, 8'h00, 1'b0, 24'h0, 24'h0, 24'h0},
         '{CMD_CLEAR,   5'd0,  8'hFF, 8'hFF, 8'hFF, 1'b0, 24'h0, 24'h0, 24'h0},
         '{CMD_REFRESH, 5'd5,  8'h00, 8'h00, 8'h00, 1'b1, ZERO_CODE, ZERO_CODE, ZERO_CODE},
         '{CMD_SET,     5'd23, 8'hFF, 8'hFF, 8'hFF, 1'b0, 24'h0, 24'h0, 24'h0},
         '{CMD_SET,     5'd23, 8'h00, 8'h00, 8'h00, 1'b0, 24'h0, 24'h0, 24'h0},
         '{CMD_REFRESH, 5'd23, 8'h00, 8'h00, 8'h00, 1'b1, ZERO_CODE, ZERO_CODE, ZERO_CODE},
         '{CMD_SET,     5'd0,  8'hFF, 8'h00, 8'hFF, 1'b0, 24'h0, 24'h0, 24'h0},
         '{CMD_REFRESH, 5'd0,  8'h00, 8'h00, 8'h00, 1'b1, ZERO_CODE, ONE_CODE, ONE_CODE}
      };

      @(negedge reset);
      @(negedge clock);
      foreach (directed_rows[i]) send_request(directed_rows[i]);

      // Mostly lamp writes with a refresh now and then; ignored requests are not counted.
      useful = 0;
      paused = 1'b0;
      while (useful < RANDOM_ITEMS) begin
         row.idx        = INDEX_W'($urandom_range(0, LAMPS - 1));
         row.red        = pick_byte();
         row.green      = pick_byte();
         row.blue       = pick_byte();
         row.typed      = 1'b0;
         row.green_code = '0;
         row.red_code   = '0;
         row.blue_code  = '0;
         sel = $urandom_range(0, 99);
         if (sel < 72) begin
            row.cmd = CMD_SET;
            useful++;
         end else if (sel < 78) begin
            row.cmd = CMD_SET;
            row.idx = INDEX_W'($urandom_range(LAMPS, 31));
         end else if (sel < 83) begin
            row.cmd = CMD_CLEAR;
            useful++;
         end else if (sel < 96) begin
            row.cmd = CMD_REFRESH;
            row.idx = INDEX_W'($urandom_range(0, 31));
            useful++;
         end else begin
            row.cmd = CMD_UNUSED;
         end
         send_request(row);

         // Once, hold further requests until every queued lamp result has drained.
         if (!paused && useful >= RANDOM_ITEMS / 2) begin
            paused = 1'b1;
            req_bus.valid <= 1'b0;
            while (pending_lamps.size() != 0) @(negedge clock);
            @(negedge clock);
         end
      end
      req_bus.valid <= 1'b0;

      while (pending_lamps.size() != 0) @(posedge clock);
      repeat (2 * LAMPS) @(posedge clock);

      $display("Sent %0d requests including %0d refreshes; checked %0d lamp results.",
               requests_sent, refreshes, lamps_checked);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Timed out with %0d lamp results still outstanding.", pending_lamps.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
